[src/mrr_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// mrr_pkg: shared types for the Miller-Rabin round block
// Holds the state codes of the sequencer and the modular-multiply opcodes.
// ---------------------------------------------------------------------------
package mrr_pkg;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_STRIP  = 8'b0000_0010,
    ST_REDUCE = 8'b0000_0100,
    ST_POW    = 8'b0000_1000,
    ST_WAIT   = 8'b0001_0000,
    ST_CHECK  = 8'b0010_0000,
    ST_SQR    = 8'b0100_0000,
    ST_OUT    = 8'b1000_0000
  } state_e;

  // What the pending multiply result updates.
  typedef enum logic [2:0] {
    OP_ACC = 3'b001,
    OP_BASE = 3'b010,
    OP_X = 3'b100
  } mul_op_e;

endpackage : mrr_pkg
`default_nettype wire

[src/mrr_mulmod.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// mrr_mulmod: iterative modular multiplier
// Computes x*y mod n with one bit of y per cycle (double-and-add).
// Needs x, y < n.
// ---------------------------------------------------------------------------
module mrr_mulmod #(
  parameter int unsigned W = 32
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] x_i,
  input  wire logic [W-1:0] y_i,
  input  wire logic [W-1:0] n_i,
  output logic              done_o,
  output logic [W-1:0]      r_o
);

  localparam int unsigned CW = $clog2(W + 1);

  logic          busy_q, busy_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  r_q, r_d, x_q, x_d, y_q, y_d, n_q, n_d;
  logic          done_q, done_d;
  logic [W:0]    dbl, dbl_red, add, add_red;

  always_comb begin
    // r2 = 2r mod n, then add x mod n when this bit of y is set.
    dbl     = {r_q, 1'b0};
    dbl_red = (dbl >= {1'b0, n_q}) ? dbl - {1'b0, n_q} : dbl;
    add     = dbl_red + {1'b0, x_q};
    add_red = (add >= {1'b0, n_q}) ? add - {1'b0, n_q} : add;

    busy_d = busy_q;
    cnt_d  = cnt_q;
    r_d    = r_q;
    x_d    = x_q;
    y_d    = y_q;
    n_d    = n_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(W);
      r_d    = '0;
      x_d    = x_i;
      y_d    = y_i;
      n_d    = n_i;
    end else if (busy_q) begin
      r_d   = y_q[W-1] ? add_red[W-1:0] : dbl_red[W-1:0];
      y_d   = {y_q[W-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    x_q <= x_d;
    y_q <= y_d;
    n_q <= n_d;
  end

  assign done_o = done_q;
  assign r_o    = r_q;

endmodule : mrr_mulmod
`default_nettype wire

[src/miller_rabin_round_top.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// miller_rabin_round_top: one Miller-Rabin round per beat
// Sequencer around a shared bit-serial modular multiplier.
// ---------------------------------------------------------------------------
// One input beat (candidate n, witness a) yields one verdict beat. The block
// takes one beat at a time: in_stall_o is high from acceptance until the
// verdict is taken. Each item with n > 4 first strips factors of two from
// n - 1, then reduces the witness (W = NUM_WIDTH). The exponentiation then
// costs one squaring for every bit of d, plus one multiply for every set
// bit, followed by at most s - 1 further squarings. Every multiply runs on
// the single double-and-add multiplier. Since d has at most W - s bits, the
// worst case is an odd n - 1 with as many bits set as n allows. The witness
// is reduced mod n by a one-bit-per-cycle restoring division.
module miller_rabin_round_top
  import mrr_pkg::*;
#(
  parameter int unsigned NUM_WIDTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] candidate_i,
  input  wire logic [31:0] witness_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             probably_prime_o
);

  localparam int unsigned W  = NUM_WIDTH;
  localparam int unsigned CW = $clog2(W + 1);

  state_e        st_q, st_d;
  mul_op_e       op_q, op_d;
  logic [W-1:0]  n_q, n_d, d_q, d_d, acc_q, acc_d, base_q, base_d, a_q, a_d;
  logic [W-1:0]  nm1;
  logic [CW-1:0] s_q, s_d, cnt_q, cnt_d;
  logic          res_q, res_d;
  logic          m_start, m_done;
  logic [W-1:0]  m_x, m_y, m_r;
  logic [W:0]    rem_sh;
  logic [W-1:0]  cand_w, wit_w;

  assign nm1 = n_q - 1'b1;

  always_comb begin
    cand_w = W'(64'(candidate_i));
    wit_w  = W'(64'(witness_i));
  end

  mrr_mulmod #(.W(W)) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(m_start),
    .x_i    (m_x),
    .y_i    (m_y),
    .n_i    (n_q),
    .done_o (m_done),
    .r_o    (m_r)
  );

  always_comb begin
    st_d    = st_q;
    op_d    = op_q;
    n_d     = n_q;
    d_d     = d_q;
    acc_d   = acc_q;
    base_d  = base_q;
    a_d     = a_q;
    s_d     = s_q;
    cnt_d   = cnt_q;
    res_d   = res_q;
    m_start = 1'b0;
    m_x     = acc_q;
    m_y     = base_q;
    // Restoring division step: remainder in base, dividend bits from a.
    rem_sh  = {base_q, a_q[W-1]};

    unique case (st_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          n_d   = cand_w;
          a_d   = wit_w;
          d_d   = cand_w - 1'b1;
          s_d   = '0;
          base_d = '0;
          cnt_d = CW'(W);
          if (cand_w <= W'(1) || cand_w == W'(4)) begin
            res_d = 1'b0;
            st_d  = ST_OUT;
          end else if (cand_w <= W'(3)) begin
            res_d = 1'b1;
            st_d  = ST_OUT;
          end else begin
            st_d = ST_STRIP;
          end
        end
      end
      ST_STRIP: begin
        if (!d_q[0] && d_q != '0) begin
          d_d = d_q >> 1;
          s_d = s_q + 1'b1;
        end else begin
          st_d = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        base_d = (rem_sh >= {1'b0, n_q}) ? W'(rem_sh - {1'b0, n_q}) : rem_sh[W-1:0];
        a_d    = {a_q[W-2:0], 1'b0};
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          acc_d = W'(1);
          st_d  = ST_POW;
        end
      end
      ST_POW: begin
        if (d_q == '0) begin
          st_d = ST_CHECK;
        end else begin
          m_start = 1'b1;
          if (d_q[0]) begin
            op_d = OP_ACC;
          end else begin
            m_x  = base_q;
            op_d = OP_BASE;
          end
          st_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (m_done) begin
          unique case (op_q)
            OP_ACC: begin
              acc_d   = m_r;
              m_start = 1'b1;
              m_x     = base_q;
              op_d    = OP_BASE;
            end
            OP_BASE: begin
              base_d = m_r;
              d_d    = d_q >> 1;
              st_d   = ST_POW;
            end
            OP_X: begin
              acc_d = m_r;
              if (m_r == W'(1)) begin
                res_d = 1'b0;
                st_d  = ST_OUT;
              end else if (m_r == nm1) begin
                res_d = 1'b1;
                st_d  = ST_OUT;
              end else begin
                s_d  = s_q - 1'b1;
                st_d = ST_SQR;
              end
            end
            default: st_d = ST_IDLE;
          endcase
        end
      end
      ST_CHECK: begin
        if (acc_q == W'(1) || acc_q == nm1) begin
          res_d = 1'b1;
          st_d  = ST_OUT;
        end else begin
          st_d = ST_SQR;
        end
      end
      ST_SQR: begin
        // Up to s-1 further squarings.
        if (s_q <= CW'(1)) begin
          res_d = 1'b0;
          st_d  = ST_OUT;
        end else begin
          m_start = 1'b1;
          m_x     = acc_q;
          m_y     = acc_q;
          op_d    = OP_X;
          st_d    = ST_WAIT;
        end
      end
      ST_OUT: begin
        if (!out_stall_i) st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      op_q <= OP_ACC;
    end else begin
      st_q <= st_d;
      op_q <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    d_q    <= d_d;
    acc_q  <= acc_d;
    base_q <= base_d;
    a_q    <= a_d;
    s_q    <= s_d;
    cnt_q  <= cnt_d;
    res_q  <= res_d;
  end

  assign in_stall_o       = (st_q != ST_IDLE);
  assign out_valid_o      = (st_q == ST_OUT);
  assign probably_prime_o = res_q;

endmodule : miller_rabin_round_top
`default_nettype wire
